FILE: design/jet_pkg.sv
// Package for the Julia escape-time pixel unit.
// Register map codes, configuration field widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package jet_pkg;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd4;

  // Register field widths
  localparam int C_W       = 30;
  localparam int LIM_CFG_W = 9;
  localparam int DIM_CFG_W = 13;

  // Reset values
  localparam logic signed [C_W-1:0]   C_RE_RST  = -30'sd187904819;
  localparam logic signed [C_W-1:0]   C_IM_RST  = 30'sd72517838;
  localparam logic [LIM_CFG_W-1:0]    LIM_RST   = 9'd256;
  localparam logic [DIM_CFG_W-1:0]    DIM_RST   = 13'd1024;

endpackage

FILE: design/jet_in_if.sv
// Pixel coordinate channel: valid/ready handshake with column and row index.
// Depends on nothing.
`timescale 1ns / 1ps

interface jet_in_if #(parameter int IDX_W = 12);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] column;
  logic [IDX_W-1:0] row_index;

  modport source (output valid, output column, output row_index, input ready);
  modport sink   (input valid, input column, input row_index, output ready);
endinterface

FILE: design/jet_out_if.sv
// Result channel: valid/ready handshake with iteration count and colour ramp.
// Depends on nothing.
`timescale 1ns / 1ps

interface jet_out_if #(parameter int IT_W = 9);
  logic            valid;
  logic            ready;
  logic [IT_W-1:0] iterations_done;
  logic [7:0]      red;
  logic [7:0]      blue;

  modport source (output valid, output iterations_done, output red, output blue,
                  input ready);
  modport sink   (input valid, input iterations_done, input red, input blue,
                  output ready);
endinterface

FILE: design/jet_udiv.sv
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Carries the divisor and a sideband word alongside; depends on nothing.
`timescale 1ns / 1ps

module jet_udiv #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic          vld_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [NW-1:0] quo_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          p_vld;
    logic [DW-1:0] p_rem;
    logic [NW-1:0] p_num;
    logic [NW-1:0] p_quo;
    logic [DW-1:0] p_den;
    logic [SW-1:0] p_side;
    logic [DW:0]   trial;
    logic          ge;

    // previous stage, or the inputs for the first one
    if (k == 0) begin : g_first
      assign p_vld  = vld_i;
      assign p_rem  = '0;
      assign p_num  = num_i;
      assign p_quo  = '0;
      assign p_den  = den_i;
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_r[k-1];
      assign p_rem  = rem_r[k-1];
      assign p_num  = num_r[k-1];
      assign p_quo  = quo_r[k-1];
      assign p_den  = den_r[k-1];
      assign p_side = side_r[k-1];
    end

    // shift in the next dividend bit and try the subtraction
    assign trial = {p_rem, p_num[NW-1]};
    assign ge    = trial >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? DW'(trial - {1'b0, p_den}) : DW'(trial);
        num_r[k]  <= {p_num[NW-2:0], 1'b0};
        quo_r[k]  <= {p_quo[NW-2:0], ge};
        den_r[k]  <= p_den;
        side_r[k] <= p_side;
      end
    end
  end

  assign vld_o  = vld_r[NW-1];
  assign quo_o  = quo_r[NW-1];
  assign side_o = side_r[NW-1];

endmodule

FILE: design/jet_iter_stage.sv
// One z = z*z + c iteration in two register stages: products, then escape
// test, fold back to the fixed-point word and saturate. Uses jet_pkg.
`timescale 1ns / 1ps

module jet_iter_stage #(
  parameter int QW   = 32,
  parameter int F    = 28,
  parameter int IT_W = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [QW-1:0]          re_i,
  input  logic signed [QW-1:0]          im_i,
  input  logic [IT_W-1:0]               it_i,
  input  logic                          done_i,
  input  logic [IT_W-1:0]               lim_i,
  input  logic signed [jet_pkg::C_W-1:0] c_re_i,
  input  logic signed [jet_pkg::C_W-1:0] c_im_i,
  output logic                          vld_o,
  output logic signed [QW-1:0]          re_o,
  output logic signed [QW-1:0]          im_o,
  output logic [IT_W-1:0]               it_o,
  output logic                          done_o
);
  import jet_pkg::*;

  localparam int PW = 2 * QW;
  localparam int WW = 2 * QW + 2;
  localparam logic signed [QW-1:0] Q_TWO   = QW'(1) << (F + 1);
  localparam logic signed [QW-1:0] Q_MAX   = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN   = {1'b1, {(QW-1){1'b0}}};
  localparam logic [PW:0]          FOUR_SQ = (PW+1)'(1) << (2 * F + 2);

  function automatic logic signed [QW-1:0] sat_q(input logic signed [WW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > WW'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < WW'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = QW'(v);
    end
    return r;
  endfunction

  // Stage A: coarse magnitude check and the three products
  logic                 big;
  logic                 a_vld_r;
  logic signed [PW-1:0] a_rr_r, a_ii_r, a_ri_r;
  logic [IT_W-1:0]      a_it_r;
  logic                 a_done_r;

  assign big = (re_i >= Q_TWO) || (re_i <= -Q_TWO) ||
               (im_i >= Q_TWO) || (im_i <= -Q_TWO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rr_r   <= re_i * re_i;
      a_ii_r   <= im_i * im_i;
      a_ri_r   <= re_i * im_i;
      a_it_r   <= it_i;
      a_done_r <= done_i || big || (it_i >= lim_i);
    end
  end

  // Stage B: exact |z|^2 test, floor shift, add c, saturate
  logic [PW:0]          sum;
  logic                 esc;
  logic signed [WW-1:0] diff, ri2, fre, fim;
  logic                 b_done_nxt;
  logic                 b_vld_r, b_done_r;
  logic signed [QW-1:0] b_re_r, b_im_r;
  logic [IT_W-1:0]      b_it_r;

  assign sum        = {1'b0, a_rr_r} + {1'b0, a_ii_r};
  assign esc        = sum >= FOUR_SQ;
  assign diff       = WW'(a_rr_r) - WW'(a_ii_r);
  assign ri2        = WW'(a_ri_r) <<< 1;
  assign fre        = (diff >>> F) + WW'(c_re_i);
  assign fim        = (ri2 >>> F) + WW'(c_im_i);
  assign b_done_nxt = a_done_r || esc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_done_r <= b_done_nxt;
      if (!b_done_nxt) begin
        b_re_r <= sat_q(fre);
        b_im_r <= sat_q(fim);
        b_it_r <= a_it_r + IT_W'(1);
      end else begin
        b_it_r <= a_it_r;
      end
    end
  end

  assign vld_o  = b_vld_r;
  assign re_o   = b_re_r;
  assign im_o   = b_im_r;
  assign it_o   = b_it_r;
  assign done_o = b_done_r;

endmodule

FILE: design/julia_escape_time_pixel_unit.sv
// Julia escape-time pixel unit: top level with register file, start-point
// dividers, unrolled iteration pipeline and colour divider.
// Depends on jet_pkg, jet_in_if, jet_out_if, jet_udiv, jet_iter_stage.
//
// Usage: present a pixel (column, row_index) on in_px; each transaction
// yields exactly one result on out_res: the iteration count, red and blue.
// Configuration (c, iteration limit, image size) must be written over the APB
// port only while the unit is empty; the unit itself does not enforce this.
// Reads return the register contents. Throughput: one pixel per clock while
// out_res is not stalled. Every iteration up to ITER_LIMIT_MAX has its own
// two register stages, so a pixel runs all of them regardless of when it
// escapes. Pipeline: stage 0, the start-point dividers (one quotient bit per
// stage), stage 1, the iteration chain, the colour divider and the output
// register.
// Reset: synchronous, active low; empties the pipeline and loads the
// register defaults (c = -0.7 + 0.27015i, limit 256, 1024 x 1024).
// Stall: the whole pipeline holds while a result waits in the output
// register and out_res.ready is low; in_px.ready drops in the same cycle,
// so nothing is lost or repeated.
`timescale 1ns / 1ps

module julia_escape_time_pixel_unit #(
  parameter int ITER_LIMIT_MAX = 256,
  parameter int DIM_MAX        = 4096,
  parameter int FRAC_BITS      = 28
) (
  input  logic                           clk,
  input  logic                           rst_n,
  jet_in_if.sink                         in_px,
  jet_out_if.source                      out_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jet_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jet_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jet_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import jet_pkg::*;

  localparam int IDX_W = $clog2(DIM_MAX);
  localparam int IT_W  = $clog2(ITER_LIMIT_MAX + 1);
  localparam int QW    = FRAC_BITS + 4;
  localparam int NUM_W = ((IDX_W + 1 > DIM_CFG_W) ? IDX_W + 1 : DIM_CFG_W) + 1;
  localparam int NW_C  = NUM_W + FRAC_BITS;
  localparam int NW_R  = IT_W + 8;
  localparam int N     = ITER_LIMIT_MAX;
  localparam logic [NW_C-1:0]      Q_LIM = NW_C'(1) << (QW - 1);
  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  // ---------------- configuration registers ----------------
  logic signed [C_W-1:0]  c_re_r, c_im_r;
  logic [LIM_CFG_W-1:0]   lim_cfg_r;
  logic [DIM_CFG_W-1:0]   wid_r, hgt_r;
  logic [CFG_IDX_W-1:0]   reg_idx;
  logic                   cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_re_r    <= C_RE_RST;
      c_im_r    <= C_IM_RST;
      lim_cfg_r <= LIM_RST;
      wid_r     <= DIM_RST;
      hgt_r     <= DIM_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_C_REAL:   c_re_r    <= pwdata[C_W-1:0];
        REG_C_IMAG:   c_im_r    <= pwdata[C_W-1:0];
        REG_MAX_ITER: lim_cfg_r <= pwdata[LIM_CFG_W-1:0];
        REG_WIDTH:    wid_r     <= pwdata[DIM_CFG_W-1:0];
        REG_HEIGHT:   hgt_r     <= pwdata[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (reg_idx)
      REG_C_REAL:   prdata = {{(CFG_DATA_W-C_W){c_re_r[C_W-1]}}, c_re_r};
      REG_C_IMAG:   prdata = {{(CFG_DATA_W-C_W){c_im_r[C_W-1]}}, c_im_r};
      REG_MAX_ITER: prdata = CFG_DATA_W'(lim_cfg_r);
      REG_WIDTH:    prdata = CFG_DATA_W'(wid_r);
      REG_HEIGHT:   prdata = CFG_DATA_W'(hgt_r);
      default:      prdata = '0;
    endcase
  end

  // effective limit and dimensions
  logic [IT_W-1:0]      lim_eff;
  logic [DIM_CFG_W-1:0] wid_eff, hgt_eff;

  always_comb begin
    if (lim_cfg_r == '0) begin
      lim_eff = IT_W'(1);
    end else if (32'(lim_cfg_r) > 32'(ITER_LIMIT_MAX)) begin
      lim_eff = IT_W'(ITER_LIMIT_MAX);
    end else begin
      lim_eff = IT_W'(lim_cfg_r);
    end
  end

  assign wid_eff = (wid_r == '0) ? DIM_CFG_W'(1) : wid_r;
  assign hgt_eff = (hgt_r == '0) ? DIM_CFG_W'(1) : hgt_r;

  // ---------------- pipeline enable ----------------
  logic out_vld_r;
  logic en;

  assign en          = !out_vld_r || out_res.ready;
  assign in_px.ready = en;

  // ---------------- stage 0: signed numerators ----------------
  logic signed [NUM_W-1:0] num_x, num_y;
  logic                    s0_vld_r;
  logic [NUM_W-1:0]        s0_mx_r, s0_my_r;
  logic                    s0_nx_r, s0_ny_r;

  assign num_x = NUM_W'({in_px.column, 1'b0}) - NUM_W'(wid_eff);
  assign num_y = NUM_W'({in_px.row_index, 1'b0}) - NUM_W'(hgt_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_nx_r <= num_x[NUM_W-1];
      s0_ny_r <= num_y[NUM_W-1];
      s0_mx_r <= num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
      s0_my_r <= num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
    end
  end

  // ---------------- start-point dividers ----------------
  logic            dx_vld, dy_vld;
  logic [NW_C-1:0] qx, qy;
  logic            dx_neg, dy_neg;

  jet_udiv #(.NW(NW_C), .DW(DIM_CFG_W), .SW(1)) u_div_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s0_vld_r),
    .num_i  ({s0_mx_r, {FRAC_BITS{1'b0}}}),
    .den_i  (wid_eff),
    .side_i (s0_nx_r),
    .vld_o  (dx_vld),
    .quo_o  (qx),
    .side_o (dx_neg)
  );

  jet_udiv #(.NW(NW_C), .DW(DIM_CFG_W), .SW(1)) u_div_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s0_vld_r),
    .num_i  ({s0_my_r, {FRAC_BITS{1'b0}}}),
    .den_i  (hgt_eff),
    .side_i (s0_ny_r),
    .vld_o  (dy_vld),
    .quo_o  (qy),
    .side_o (dy_neg)
  );

  // ---------------- stage 1: signed, saturated start point ----------------
  function automatic logic signed [QW-1:0] to_q(input logic [NW_C-1:0] q,
                                                 input logic neg);
    logic signed [QW-1:0] r;
    if (neg) begin
      r = (q > Q_LIM) ? Q_MIN : -QW'(q);
    end else begin
      r = (q > Q_LIM - NW_C'(1)) ? Q_MAX : QW'(q);
    end
    return r;
  endfunction

  logic                 s1_vld_r;
  logic signed [QW-1:0] s1_re_r, s1_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= dx_vld && dy_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_re_r <= to_q(qx, dx_neg);
      s1_im_r <= to_q(qy, dy_neg);
    end
  end

  // ---------------- iteration chain ----------------
  logic                 st_vld  [N+1];
  logic signed [QW-1:0] st_re   [N+1];
  logic signed [QW-1:0] st_im   [N+1];
  logic [IT_W-1:0]      st_it   [N+1];
  logic                 st_done [N+1];

  assign st_vld[0]  = s1_vld_r;
  assign st_re[0]   = s1_re_r;
  assign st_im[0]   = s1_im_r;
  assign st_it[0]   = '0;
  assign st_done[0] = 1'b0;

  for (genvar k = 0; k < N; k++) begin : g_iter
    jet_iter_stage #(.QW(QW), .F(FRAC_BITS), .IT_W(IT_W)) u_iter (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (st_vld[k]),
      .re_i   (st_re[k]),
      .im_i   (st_im[k]),
      .it_i   (st_it[k]),
      .done_i (st_done[k]),
      .lim_i  (lim_eff),
      .c_re_i (c_re_r),
      .c_im_i (c_im_r),
      .vld_o  (st_vld[k+1]),
      .re_o   (st_re[k+1]),
      .im_o   (st_im[k+1]),
      .it_o   (st_it[k+1]),
      .done_o (st_done[k+1])
    );
  end

  // ---------------- colour ramp: 255 * count / limit ----------------
  logic [NW_R-1:0] scaled;
  logic            cd_vld;
  logic [NW_R-1:0] cd_quo;
  logic [IT_W-1:0] cd_it;

  assign scaled = {st_it[N], 8'd0} - NW_R'(st_it[N]);

  jet_udiv #(.NW(NW_R), .DW(IT_W), .SW(IT_W)) u_div_colour (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (st_vld[N]),
    .num_i  (scaled),
    .den_i  (lim_eff),
    .side_i (st_it[N]),
    .vld_o  (cd_vld),
    .quo_o  (cd_quo),
    .side_o (cd_it)
  );

  // ---------------- output register ----------------
  logic [IT_W-1:0] out_it_r;
  logic [7:0]      out_red_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= cd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_it_r  <= cd_it;
      out_red_r <= cd_quo[7:0];
    end
  end

  assign out_res.valid           = out_vld_r;
  assign out_res.iterations_done = out_it_r;
  assign out_res.red             = out_red_r;
  assign out_res.blue            = 8'd255 - out_red_r;

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_res.valid)
    else $error("result valid straight after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (32'(out_res.iterations_done) <= 32'(ITER_LIMIT_MAX)))
    else $error("iteration count beyond the unrolled depth");

  a_chain_full: assert property (@(posedge clk) disable iff (!rst_n)
    (st_vld[N] && !st_done[N]) |-> (32'(st_it[N]) == 32'(N)))
    else $error("unfinished pixel left the chain with a short count");

endmodule

FILE: verif/tb_julia_escape_time_pixel_unit.sv
// Self-checking testbench for the Julia escape-time pixel unit.
// Predicts count, red and blue per pixel and checks them in order.
// Depends on jet_pkg, jet_in_if, jet_out_if and julia_escape_time_pixel_unit.
`timescale 1ns / 1ps

module tb_julia_escape_time_pixel_unit;
  import jet_pkg::*;

  localparam int  FRAC      = 28;
  localparam int  LIM_MAX   = 256;
  localparam int  LATENCY   = 574;
  localparam longint Q_MAX  = (64'sd1 <<< (FRAC + 3)) - 1;
  localparam longint Q_MIN  = -Q_MAX - 1;
  localparam longint Q_TWO  = 64'sd2 <<< FRAC;
  localparam longint Q_FOUR = 64'sd4 <<< (2 * FRAC);
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [8:0] iters;
    logic [7:0] red;
    logic [7:0] blue;
  } pixel_res_t;

  // Predicts each pixel and holds the expected results in order
  class pixel_scoreboard;
    longint c_re, c_im;
    int lim_cfg, width_cfg, height_cfg;
    pixel_res_t pending[$];
    int mismatches;

    function new();
      c_re = -187904819; c_im = 72517838;
      lim_cfg = 256; width_cfg = 1024; height_cfg = 1024;
      mismatches = 0;
    endfunction

    function longint clamp_q(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function longint start_point(int idx, int dim);
      longint num, mag, q;
      if (dim == 0) dim = 1;
      num = 2 * longint'(idx) - dim;
      mag = num < 0 ? -num : num;
      q = (mag <<< FRAC) / dim;
      if (num < 0) return q > Q_MAX + 1 ? Q_MIN : -q;
      return q > Q_MAX ? Q_MAX : q;
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row);
      int lim, it, red;
      longint re, im, rr, ii, ri, nre;
      pixel_res_t r;
      lim = lim_cfg;
      if (lim == 0) lim = 1;
      if (lim > LIM_MAX) lim = LIM_MAX;
      re = start_point(int'(col), width_cfg);
      im = start_point(int'(row), height_cfg);
      it = 0;
      while (it < lim) begin
        if ((re < 0 ? -re : re) >= Q_TWO || (im < 0 ? -im : im) >= Q_TWO) break;
        rr = re * re;
        ii = im * im;
        if (rr + ii >= Q_FOUR) break;
        ri = 2 * re * im;
        // arithmetic shift is a floor
        nre = clamp_q(((rr - ii) >>> FRAC) + c_re);
        im = clamp_q((ri >>> FRAC) + c_im);
        re = nre;
        it++;
      end
      red = (255 * it) / lim;
      r.iters = it[8:0];
      r.red = red[7:0];
      r.blue = 8'(255 - red);
      pending.push_back(r);
    endfunction

    function void check_result(pixel_res_t got);
      pixel_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: iters=%0d red=%0d blue=%0d",
                   got.iters, got.red, got.blue);
        return;
      end
      exp_r = pending.pop_front();
      if (got.iters !== exp_r.iters || got.red !== exp_r.red || got.blue !== exp_r.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected iters=%0d red=%0d blue=%0d, got %0d %0d %0d",
                   exp_r.iters, exp_r.red, exp_r.blue, got.iters, got.red, got.blue);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;
  logic pready;

  jet_in_if  #(.IDX_W(12)) px_if ();
  jet_out_if #(.IT_W(9))   res_if ();

  julia_escape_time_pixel_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_px(px_if.sink), .out_res(res_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pixel_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int hold_off;
  longint cycles;
  int w_cur, h_cur;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_julia_escape_time_pixel_unit: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, optional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      sb.check_result({res_if.iterations_done, res_if.red, res_if.blue});
  end

  // APB register write: setup then access
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_C_REAL:   sb.c_re = longint'($signed(val[29:0]));
      REG_C_IMAG:   sb.c_im = longint'($signed(val[29:0]));
      REG_MAX_ITER: sb.lim_cfg = int'(val[8:0]);
      REG_WIDTH:    begin sb.width_cfg = int'(val[12:0]); w_cur = int'(val[12:0]); end
      REG_HEIGHT:   begin sb.height_cfg = int'(val[12:0]); h_cur = int'(val[12:0]); end
      default: ;
    endcase
  endtask

  // Offer one pixel, hold until accepted
  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      px_if.valid <= 1'b0;
      @(negedge clk);
    end
    px_if.valid <= 1'b1;
    px_if.column <= col;
    px_if.row_index <= row;
    do @(posedge clk); while (!px_if.ready);
    sb.note_pixel(col, row);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
  endtask

  // Mostly in-image pixels; occasionally anything
  task automatic random_pixels(int n);
    logic [11:0] c, r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        c = 12'($urandom); r = 12'($urandom);
      end else begin
        c = 12'($urandom_range((w_cur > 1 ? w_cur : 1) - 1));
        r = 12'($urandom_range((h_cur > 1 ? h_cur : 1) - 1));
      end
      send_pixel(c, r);
    end
    px_if.valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    cycles = 0; hold_off = 0; w_cur = 1024; h_cur = 1024;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    px_if.valid = 1'b0; px_if.column = '0; px_if.row_index = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, corners, centre, out-of-image indexes
    send_idle_pct = 32; recv_idle_pct = 47;
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(512, 512);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(600, 400);
    px_if.valid <= 1'b0;
    drain();

    // Zero dimensions and a limit of zero; extremes of c
    cfg_write(REG_WIDTH, 0);
    cfg_write(REG_HEIGHT, 0);
    cfg_write(REG_MAX_ITER, 0);
    cfg_write(REG_C_REAL, 32'h2000_0000);
    cfg_write(REG_C_IMAG, 32'h1FFF_FFFF);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(4095, 4095);
    px_if.valid <= 1'b0;
    drain();

    // Limit above range, tiny image, c = 0
    cfg_write(REG_MAX_ITER, 511);
    cfg_write(REG_WIDTH, 2);
    cfg_write(REG_HEIGHT, 1);
    cfg_write(REG_C_REAL, 0);
    cfg_write(REG_C_IMAG, 0);
    send_pixel(1, 0);
    send_pixel(0, 0);
    send_pixel(2, 1);
    px_if.valid <= 1'b0;
    drain();

    // Largest image, limit 1
    cfg_write(REG_WIDTH, 4096);
    cfg_write(REG_HEIGHT, 4096);
    cfg_write(REG_MAX_ITER, 1);
    cfg_write(REG_C_REAL, 32'h3FFF_FFFF);
    send_pixel(2048, 2048);
    send_pixel(4095, 0);
    px_if.valid <= 1'b0;
    drain();

    // Random phase 1: classic constant, small image, long receiver hold-off
    cfg_write(REG_C_REAL, -187904819);
    cfg_write(REG_C_IMAG, 72517838);
    cfg_write(REG_MAX_ITER, 256);
    cfg_write(REG_WIDTH, 64);
    cfg_write(REG_HEIGHT, 48);
    hold_off = 1500;
    random_pixels(700);
    drain();

    // Phase 2: swapped idling, random settings
    send_idle_pct = 47; recv_idle_pct = 32;
    cfg_write(REG_C_REAL, $urandom_range(32'h2000_0000) - 32'h1000_0000);
    cfg_write(REG_C_IMAG, $urandom);
    cfg_write(REG_MAX_ITER, $urandom_range(256, 1));
    cfg_write(REG_WIDTH, $urandom_range(4096, 1));
    cfg_write(REG_HEIGHT, $urandom_range(300, 1));
    random_pixels(650);
    drain();

    // Phase 3: no idling
    send_idle_pct = 0; recv_idle_pct = 0;
    cfg_write(REG_C_REAL, $urandom_range(32'h0800_0000) - 32'h0400_0000);
    cfg_write(REG_C_IMAG, $urandom_range(32'h0800_0000) - 32'h0400_0000);
    cfg_write(REG_MAX_ITER, $urandom_range(200, 20));
    cfg_write(REG_WIDTH, 100);
    cfg_write(REG_HEIGHT, 4096);
    random_pixels(650);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_julia_escape_time_pixel_unit: done, clean");
    else
      $display("tb_julia_escape_time_pixel_unit: done, errors");
    $finish;
  end

endmodule

FILE: files.f
design/jet_pkg.sv
design/jet_in_if.sv
design/jet_out_if.sv
design/jet_udiv.sv
design/jet_iter_stage.sv
design/julia_escape_time_pixel_unit.sv
verif/tb_julia_escape_time_pixel_unit.sv
